// File: rtl/tmq_pkg.sv
// Shared types, command and status codes for the timed message queue.
`timescale 1ns / 1ps

package tmq_pkg;

  // Default number of queue slots
  localparam int TMQ_DEPTH = 16;

  // Field widths
  localparam int TIME_W   = 48;
  localparam int TARGET_W = 8;
  localparam int CODE_W   = 16;
  localparam int ARG_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int QCNT_W   = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQUEUE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POLL      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_CODED = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_CB    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUIT      = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_QUIT    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NONE    = 2'd3;

  // One stored queue entry
  typedef struct packed {
    logic [TIME_W-1:0]          due;
    logic [TARGET_W-1:0]        target;
    logic [CODE_W-1:0]          what;
    logic                       kind;
    logic signed [ARG_W-1:0]    arg_first;
    logic signed [ARG_W-1:0]    arg_second;
    logic [HANDLE_W-1:0]        handle;
  } entry_t;

  // Key presented to the shared compare unit
  typedef struct packed {
    logic [TIME_W-1:0]   time_key;
    logic [TARGET_W-1:0] target;
    logic [CODE_W-1:0]   what;
    logic                coded;
  } cmp_key_t;

  // Compare unit answers
  typedef struct packed {
    logic later;  // entry due strictly after the key time
    logic hit;    // entry matches the removal rule
  } cmp_res_t;

endpackage

// File: rtl/tmq_mem.sv
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module tmq_mem
  import tmq_pkg::*;
#(
  parameter int DEPTH = TMQ_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tmq_cmp.sv
// Shared compare unit: due-time order check and removal match.
`timescale 1ns / 1ps

module tmq_cmp
  import tmq_pkg::*;
(
  input  entry_t   entry,
  input  cmp_key_t key,
  output cmp_res_t res
);

  logic tgt_eq;

  assign tgt_eq    = (entry.target == key.target);
  assign res.later = (entry.due > key.time_key);

  // Coded removal hits plain messages with matching target and code; otherwise callbacks of the target
  always_comb begin
    if (key.coded) begin
      res.hit = tgt_eq && (entry.what == key.what) && !entry.kind;
    end else begin
      res.hit = tgt_eq && entry.kind;
    end
  end

endmodule

// File: rtl/timed_message_queue_unit.sv
// Top level of the timed message queue: sequencer, counters and result register.
// Quit, unused codes, rejected commands and a poll on an empty queue go straight to the result;
// enqueue moves each entry due later up one slot and then writes the new entry; poll reads the
// front entry and, if it is due, pops it and moves the rest down one slot, else reports none;
// removal walks every entry and compacts the survivors. One memory read per entry step; one word
// in flight, the next accepted once the result word is loaded. Reset empties queue, clears quitting.
`timescale 1ns / 1ps

module timed_message_queue_unit
  import tmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = TMQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           command,
  input  logic [TIME_W-1:0]          time_value,
  input  logic [TARGET_W-1:0]        target_id,
  input  logic [CODE_W-1:0]          what_code,
  input  logic                       is_callback,
  input  logic signed [ARG_W-1:0]    arg_first,
  input  logic signed [ARG_W-1:0]    arg_second,
  input  logic [HANDLE_W-1:0]        payload_handle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STAT_W-1:0]          status,
  output logic [TIME_W-1:0]          out_due_time,
  output logic [TARGET_W-1:0]        out_target,
  output logic [CODE_W-1:0]          out_what,
  output logic                       out_is_callback,
  output logic signed [ARG_W-1:0]    out_arg_first,
  output logic signed [ARG_W-1:0]    out_arg_second,
  output logic [HANDLE_W-1:0]        out_handle,
  output logic                       popped,
  output logic [QCNT_W-1:0]          queued_count,
  output logic                       quitting_flag
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_READ, S_ACT, S_FINISH} state_t;

  state_t            state;
  logic [CMD_W-1:0]  op;
  cmp_key_t          key;
  entry_t            new_entry;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     wr_idx;
  logic [CW-1:0]     count;
  logic              quit;
  logic [AW-1:0]     raddr;
  logic [STAT_W-1:0] res_status;
  logic              res_popped;
  entry_t            res_entry;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  entry_t            rdata;
  cmp_res_t          cres;
  logic [CW-1:0]     idx_dec;
  logic              accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_dec  = idx - CW'(1);

  tmq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmq_cmp u_cmp (
    .entry (rdata),
    .key   (key),
    .res   (cres)
  );

  // Memory write control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata;
    unique case (state)
      S_CHK: begin
        // insertion at the very front once every entry has moved up
        if (op == CMD_ENQUEUE && idx == '0) begin
          mem_we    = 1'b1;
          mem_wdata = new_entry;
        end
      end
      S_ACT: begin
        unique case (op)
          CMD_ENQUEUE: begin
            mem_we    = 1'b1;
            mem_waddr = idx[AW-1:0];
            mem_wdata = cres.later ? rdata : new_entry;
          end
          CMD_POLL: begin
            if (idx != '0) begin
              mem_we    = 1'b1;
              mem_waddr = idx_dec[AW-1:0];
            end
          end
          CMD_REM_CODED, CMD_REM_CB: begin
            if (!cres.hit) begin
              mem_we    = 1'b1;
              mem_waddr = wr_idx[AW-1:0];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Sequencer, queue state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      quit      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // the finish state reloads the result register itself
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op                   <= command;
            key.time_key         <= time_value;
            key.target           <= target_id;
            key.what             <= what_code;
            key.coded            <= (command == CMD_REM_CODED);
            new_entry.due        <= time_value;
            new_entry.target     <= target_id;
            new_entry.what       <= what_code;
            new_entry.kind       <= is_callback;
            new_entry.arg_first  <= arg_first;
            new_entry.arg_second <= arg_second;
            new_entry.handle     <= payload_handle;
            res_popped           <= 1'b0;
            res_entry            <= '0;
            idx                  <= (command == CMD_ENQUEUE) ? count : '0;
            wr_idx               <= '0;
            unique case (command)
              CMD_ENQUEUE: begin
                if (quit) begin
                  res_status <= STAT_QUIT;
                  state      <= S_FINISH;
                end else if (count >= CW'(QUEUE_DEPTH)) begin
                  res_status <= STAT_FULL;
                  state      <= S_FINISH;
                end else begin
                  res_status <= STAT_DONE;
                  state      <= S_CHK;
                end
              end
              CMD_POLL: begin
                if (quit) begin
                  res_status <= STAT_QUIT;
                  state      <= S_FINISH;
                end else if (count == '0) begin
                  res_status <= STAT_NONE;
                  state      <= S_FINISH;
                end else begin
                  res_status <= STAT_DONE;
                  state      <= S_CHK;
                end
              end
              CMD_REM_CODED, CMD_REM_CB: begin
                if (quit) begin
                  res_status <= STAT_QUIT;
                  state      <= S_FINISH;
                end else begin
                  res_status <= STAT_DONE;
                  state      <= S_CHK;
                end
              end
              CMD_QUIT: begin
                quit       <= 1'b1;
                count      <= '0;
                res_status <= STAT_QUIT;
                state      <= S_FINISH;
              end
              default: begin
                res_status <= STAT_DONE;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_CHK: begin
          unique case (op)
            CMD_ENQUEUE: begin
              if (idx == '0) begin
                count <= count + CW'(1);
                state <= S_FINISH;
              end else begin
                raddr <= idx_dec[AW-1:0];
                state <= S_READ;
              end
            end
            CMD_POLL: begin
              if (idx == '0) begin
                raddr <= '0;
                state <= S_READ;
              end else if (idx >= count) begin
                count <= count - CW'(1);
                state <= S_FINISH;
              end else begin
                raddr <= idx[AW-1:0];
                state <= S_READ;
              end
            end
            CMD_REM_CODED, CMD_REM_CB: begin
              if (idx >= count) begin
                count <= wr_idx;
                state <= S_FINISH;
              end else begin
                raddr <= idx[AW-1:0];
                state <= S_READ;
              end
            end
            default: state <= S_FINISH;
          endcase
        end
        S_READ: begin
          state <= S_ACT;
        end
        S_ACT: begin
          unique case (op)
            CMD_ENQUEUE: begin
              // later entries move up one slot; otherwise the new one lands here
              if (cres.later) begin
                idx   <= idx_dec;
                state <= S_CHK;
              end else begin
                count <= count + CW'(1);
                state <= S_FINISH;
              end
            end
            CMD_POLL: begin
              if (idx == '0) begin
                if (cres.later) begin
                  res_status <= STAT_NONE;
                  state      <= S_FINISH;
                end else begin
                  res_popped <= 1'b1;
                  res_entry  <= rdata;
                  idx        <= CW'(1);
                  state      <= S_CHK;
                end
              end else begin
                idx   <= idx + CW'(1);
                state <= S_CHK;
              end
            end
            CMD_REM_CODED, CMD_REM_CB: begin
              if (!cres.hit) begin
                wr_idx <= wr_idx + CW'(1);
              end
              idx   <= idx + CW'(1);
              state <= S_CHK;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_FINISH: begin
          // hand the word over once the result register is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            popped          <= res_popped;
            out_due_time    <= res_entry.due;
            out_target      <= res_entry.target;
            out_what        <= res_entry.what;
            out_is_callback <= res_entry.kind;
            out_arg_first   <= res_entry.arg_first;
            out_arg_second  <= res_entry.arg_second;
            out_handle      <= res_entry.handle;
            queued_count    <= QCNT_W'(count);
            quitting_flag   <= quit;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/tmq_checker.sv
// Port-level assertions for the timed message queue, bound to the top level.
`timescale 1ns / 1ps

module tmq_checker
  import tmq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STAT_W-1:0]   status,
  input logic [TIME_W-1:0]   out_due_time,
  input logic [HANDLE_W-1:0] out_handle,
  input logic                popped,
  input logic [QCNT_W-1:0]   queued_count,
  input logic                quitting_flag
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(popped)
      && $stable(queued_count))
    else $error("result word changed while stalled");

  // No popped entry means zero entry fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !popped |-> out_due_time == '0 && out_handle == '0)
    else $error("entry fields nonzero without a pop");

  // A pop always reports done
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && popped |-> status == STAT_DONE)
    else $error("pop with non-done status");

  // Once quitting the queue stays empty and nothing pops
  a_quit_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && quitting_flag |-> queued_count == '0 && !popped)
    else $error("activity after quit");

  // One word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back to back");

endmodule

bind timed_message_queue_unit tmq_checker u_tmq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .out_due_time  (out_due_time),
  .out_handle    (out_handle),
  .popped        (popped),
  .queued_count  (queued_count),
  .quitting_flag (quitting_flag)
);
